>>> design/cesc_pkg.sv
// ----------------------------------------------------------------------------
// cesc_pkg
// Shared types and constants for the capability escape decoder.
// ----------------------------------------------------------------------------
package cesc_pkg;

    // character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // control mask for caret sequences
    localparam logic [7:0] CARET_MASK = 8'h1F;

    // pad count limit and saturation limit of the delay count
    localparam logic [6:0]  MAX_PAD   = 7'd100;
    localparam logic [15:0] DELAY_MAX = 16'hFFFF;

    // output queue depth (two words can be pushed per accepted character)
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        PH_DIGITS = 3'd0,
        PH_BODY   = 3'd1,
        PH_CARET  = 3'd2,
        PH_ESC    = 3'd3,
        PH_OCT1   = 3'd4,
        PH_OCT2   = 3'd5
    } phase_t;

    // one result word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_end;
        logic [6:0] pad_count;
        logic       last;
    } result_t;

    // fixed escape map
    function automatic logic [7:0] escape_map(input logic [7:0] c);
        logic [7:0] r;
        begin
            unique case (c)
                8'h45:   r = 8'h1B; // E
                8'h6E:   r = 8'h0A; // n
                8'h72:   r = 8'h0D; // r
                8'h74:   r = 8'h09; // t
                8'h62:   r = 8'h08; // b
                8'h66:   r = 8'h0C; // f
                default: r = c;     // ^ \ : and everything else
            endcase
            return r;
        end
    endfunction

endpackage

>>> design/cesc_queue.sv
// ----------------------------------------------------------------------------
// cesc_queue
// Small queue: takes up to two words per cycle, gives one per cycle on ready.
// ----------------------------------------------------------------------------
module cesc_queue
    import cesc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [1:0]      push_n,
    input  result_t         push0,
    input  result_t         push1,
    output logic            room2,
    output logic            out_valid,
    input  logic            out_ready,
    output result_t         head
);

    result_t            mem_reg [QDEPTH];
    logic [QAW-1:0]     rd_reg;
    logic [QAW-1:0]     rd_next;
    logic [QAW-1:0]     wr_reg;
    logic [QAW-1:0]     wr_next;
    logic [QCW-1:0]     cnt_reg;
    logic [QCW-1:0]     cnt_next;
    logic               pop;
    logic [QAW-1:0]     wr1;

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != '0);
    assign head      = mem_reg[rd_reg];
    assign room2     = (cnt_reg <= QCW'(QDEPTH - 2));
    assign wr1       = wr_reg + QAW'(1);

    // pointer and count update
    always_comb
    begin
        rd_next  = pop ? rd_reg + QAW'(1) : rd_reg;
        wr_next  = wr_reg + QAW'(push_n);
        cnt_next = cnt_reg + QCW'(push_n) - QCW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem_reg[wr_reg] <= push0;
        end
        if (push_n == 2'd2)
        begin
            mem_reg[wr1] <= push1;
        end
    end

endmodule

>>> design/capability_escape_decoder.sv
// ----------------------------------------------------------------------------
// capability_escape_decoder
// Decodes capability value characters into bytes plus an end word with pad.
// ----------------------------------------------------------------------------
// A result word is registered in the result queue when its character is taken.
// Throughput: one character per cycle while the queue has room for two words and
//   each makes at most one word; a character that makes two words needs two pops.
// in_ready is high while the four-word result queue has room for two words.
// Reset (async, active low) empties the queue, clears halvings and the delay
//   count and returns to the leading-digits phase.
module capability_escape_decoder
    import cesc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        is_end,
    output logic [6:0]  pad_count,
    output logic        last
);

    phase_t         phase_reg;
    phase_t         phase_next;
    logic [15:0]    delay_reg;
    logic [15:0]    delay_next;
    logic [7:0]     oct_reg;
    logic [7:0]     oct_next;
    logic [3:0]     halvings_reg;

    logic           accept;
    logic           room2;
    logic [1:0]     push_n;
    result_t        push0;
    result_t        push1;
    result_t        head;

    logic           is_dig;
    logic [7:0]     digit;
    logic [19:0]    acc_wide;
    logic [15:0]    shifted;
    logic [6:0]     pad_val;
    logic [7:0]     oct_step;
    result_t        end_word;
    logic           emit_oct;
    logic           do_body;

    assign in_ready = room2;
    assign accept   = in_valid && in_ready;

    assign is_dig   = (in_char >= CH_ZERO) && (in_char <= CH_NINE);
    assign digit    = in_char - CH_ZERO;
    assign acc_wide = 20'(delay_reg) * 20'd10 + 20'(digit);
    assign oct_step = {oct_reg[4:0], 3'b000} | digit;

    // pad count from the delay
    assign shifted = delay_reg >> halvings_reg;
    always_comb
    begin
        if (delay_reg == '0)
            pad_val = '0;
        else if (shifted >= 16'(MAX_PAD))
            pad_val = MAX_PAD;
        else
            pad_val = 7'(shifted) + 7'd1;
    end

    assign end_word = '{out_byte: 8'h00, is_end: 1'b1, pad_count: pad_val, last: 1'b1};

    // decode one character
    always_comb
    begin
        result_t w;
        phase_next = phase_reg;
        delay_next = delay_reg;
        oct_next   = oct_reg;
        push_n     = 2'd0;
        push0      = '0;
        push1      = '0;
        emit_oct   = 1'b0;
        do_body    = 1'b0;
        w          = '0;

        unique case (phase_reg)
            PH_DIGITS:
            begin
                if (is_dig)
                begin
                    delay_next = (acc_wide > 20'(DELAY_MAX)) ? DELAY_MAX : acc_wide[15:0];
                end
                else
                begin
                    do_body = 1'b1;
                end
            end
            PH_CARET:
            begin
                phase_next = PH_BODY;
                push_n     = 2'd1;
                push0      = '{out_byte: in_char & CARET_MASK, is_end: 1'b0,
                               pad_count: 7'd0, last: 1'b1};
            end
            PH_ESC:
            begin
                if (is_dig)
                begin
                    oct_next   = digit;
                    phase_next = PH_OCT1;
                end
                else
                begin
                    phase_next = PH_BODY;
                    push_n     = 2'd1;
                    push0      = '{out_byte: escape_map(in_char), is_end: 1'b0,
                                   pad_count: 7'd0, last: 1'b1};
                end
            end
            PH_OCT1:
            begin
                if (in_char == CH_NUL || in_char == CH_COLON)
                begin
                    emit_oct = 1'b1;
                    do_body  = 1'b1;
                end
                else
                begin
                    oct_next   = oct_step;
                    phase_next = PH_OCT2;
                end
            end
            PH_OCT2:
            begin
                if (is_dig)
                begin
                    phase_next = PH_BODY;
                    push_n     = 2'd1;
                    push0      = '{out_byte: oct_step, is_end: 1'b0,
                                   pad_count: 7'd0, last: 1'b1};
                end
                else
                begin
                    emit_oct = 1'b1;
                    do_body  = 1'b1;
                end
            end
            default:
            begin
                do_body = 1'b1;
            end
        endcase

        // ordinary value character, optionally after a pending octal byte
        if (do_body)
        begin
            phase_next = PH_BODY;
            if (in_char == CH_NUL || in_char == CH_COLON)
            begin
                w          = end_word;
                phase_next = PH_DIGITS;
                delay_next = '0;
                oct_next   = '0;
            end
            else if (in_char == CH_CARET)
            begin
                phase_next = PH_CARET;
            end
            else if (in_char == CH_BSL)
            begin
                phase_next = PH_ESC;
            end
            else
            begin
                w = '{out_byte: in_char, is_end: 1'b0, pad_count: 7'd0, last: 1'b1};
            end

            if (emit_oct)
            begin
                push0 = '{out_byte: oct_reg, is_end: 1'b0, pad_count: 7'd0, last: 1'b1};
                if (phase_next == PH_BODY || phase_next == PH_DIGITS)
                begin
                    push0.last = 1'b0;
                    push1      = w;
                    push_n     = 2'd2;
                end
                else
                begin
                    push_n = 2'd1;
                end
            end
            else if (phase_next == PH_BODY || phase_next == PH_DIGITS)
            begin
                push0  = w;
                push_n = 2'd1;
            end
        end

        if (!accept)
        begin
            push_n = 2'd0;
        end
    end

    // decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_DIGITS;
            delay_reg    <= '0;
            oct_reg      <= '0;
            halvings_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                delay_reg <= delay_next;
                oct_reg   <= oct_next;
            end
            if (cfg_we)
            begin
                halvings_reg <= cfg_wdata;
            end
        end
    end

    // result words
    cesc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_n    (push_n),
        .push0     (push0),
        .push1     (push1),
        .room2     (room2),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign out_byte  = head.out_byte;
    assign is_end    = head.is_end;
    assign pad_count = head.pad_count;
    assign last      = head.last;

endmodule

>>> test/capability_escape_decoder_checker.sv
// ----------------------------------------------------------------------------
// capability_escape_decoder_checker
// Watches the character and result channels of the capability escape
// decoder, predicts the decoded words from every accepted character and
// compares each word that leaves the block with the oldest prediction.
// ----------------------------------------------------------------------------
module capability_escape_decoder_checker
    import cesc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [3:0] cfg_wdata,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_byte,
    input  logic       is_end,
    input  logic [6:0] pad_count,
    input  logic       last,
    output int         fail_count,
    output int         words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // decoder state as predicted
    phase_t      phase;
    logic [15:0] delay_acc;
    logic [7:0]  octal_value;
    logic [3:0]  halvings;

    // decoded words still owed by the block, oldest first
    result_t     expected_words[$];
    int          mismatches;
    int          words_in_step;
    int          words_seen;

    assign fail_count = mismatches;

    initial
    begin
        mismatches = 0;
        words_seen = 0;
    end

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // byte for a backslash sequence that is not octal
    function automatic logic [7:0] escaped_byte(input logic [7:0] c);
        case (c)
            "E":     return 8'h1B;
            "n":     return 8'h0A;
            "r":     return 8'h0D;
            "t":     return 8'h09;
            "b":     return 8'h08;
            "f":     return 8'h0C;
            default: return c;
        endcase
    endfunction

    // pad count carried by the end word
    function automatic logic [6:0] pad_for(input logic [15:0] d, input logic [3:0] h);
        logic [16:0] p;
        if (d == 16'd0)
            return 7'd0;
        p = 17'(d >> h) + 17'd1;
        if (p > 17'(MAX_PAD))
            p = 17'(MAX_PAD);
        return p[6:0];
    endfunction

    task automatic push_word(input logic [7:0] b, input logic e, input logic [6:0] p);
        result_t w;
        w.out_byte  = b;
        w.is_end    = e;
        w.pad_count = p;
        w.last      = 1'b0;
        expected_words.push_back(w);
        words_in_step++;
    endtask

    task automatic close_value();
        push_word(8'h00, 1'b1, pad_for(delay_acc, halvings));
        phase       = PH_DIGITS;
        delay_acc   = '0;
        octal_value = '0;
    endtask

    // character in the body of a value
    task automatic body_char(input logic [7:0] c);
        if (c == CH_NUL || c == CH_COLON)
            close_value();
        else if (c == CH_CARET)
            phase = PH_CARET;
        else if (c == CH_BSL)
            phase = PH_ESC;
        else
            push_word(c, 1'b0, 7'd0);
    endtask

    task automatic decode_char(input logic [7:0] c);
        int unsigned acc;
        logic [7:0]  digit;
        result_t     w;
        words_in_step = 0;
        digit = c - CH_ZERO;
        case (phase)
            PH_DIGITS:
            begin
                if (is_digit(c))
                begin
                    // saturating decimal accumulate
                    acc = 32'(delay_acc) * 10 + 32'(digit);
                    delay_acc = (acc > 32'(DELAY_MAX)) ? DELAY_MAX : acc[15:0];
                end
                else
                begin
                    phase = PH_BODY;
                    body_char(c);
                end
            end
            PH_CARET:
            begin
                phase = PH_BODY;
                push_word(c & CARET_MASK, 1'b0, 7'd0);
            end
            PH_ESC:
            begin
                if (is_digit(c))
                begin
                    octal_value = digit;
                    phase = PH_OCT1;
                end
                else
                begin
                    phase = PH_BODY;
                    push_word(escaped_byte(c), 1'b0, 7'd0);
                end
            end
            PH_OCT1:
            begin
                // second octal character is taken unchecked unless it ends the value
                if (c == CH_NUL || c == CH_COLON)
                begin
                    push_word(octal_value, 1'b0, 7'd0);
                    close_value();
                end
                else
                begin
                    octal_value = (octal_value << 3) | digit;
                    phase = PH_OCT2;
                end
            end
            PH_OCT2:
            begin
                phase = PH_BODY;
                if (is_digit(c))
                begin
                    octal_value = (octal_value << 3) | digit;
                    push_word(octal_value, 1'b0, 7'd0);
                end
                else
                begin
                    push_word(octal_value, 1'b0, 7'd0);
                    body_char(c);
                end
            end
            default:
            begin
                phase = PH_BODY;
                body_char(c);
            end
        endcase
        // flag the final word of this character
        if (words_in_step > 0)
        begin
            w = expected_words.pop_back();
            w.last = 1'b1;
            expected_words.push_back(w);
        end
    endtask

    task automatic check_word();
        result_t want;
        words_seen++;
        if (expected_words.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("word %0d unexpected: byte %h end %b pad %0d last %b",
                         words_seen, out_byte, is_end, pad_count, last);
        end
        else
        begin
            want = expected_words.pop_front();
            if (want.out_byte !== out_byte || want.is_end !== is_end ||
                want.pad_count !== pad_count || want.last !== last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("word %0d mismatch: expected byte %h end %b pad %0d last %b",
                             words_seen, want.out_byte, want.is_end, want.pad_count,
                             want.last);
                    $display("    got byte %h end %b pad %0d last %b",
                             out_byte, is_end, pad_count, last);
                end
            end
        end
    endtask

    // sample both channels at each edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase       = PH_DIGITS;
            delay_acc   = '0;
            octal_value = '0;
            halvings    = '0;
            expected_words.delete();
            words_pending <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_word();
            if (cfg_we)
                halvings = cfg_wdata;
            if (in_valid && in_ready)
                decode_char(in_char);
            words_pending <= expected_words.size();
        end
    end

endmodule

>>> test/capability_escape_decoder_tb.sv
// ----------------------------------------------------------------------------
// capability_escape_decoder_tb
// Drives capability value characters into the decoder: a directed set of
// corner cases, then random values built from delays, carets, escapes and
// octal sequences mixed with noise, under several halvings settings and with
// bursty input and a stalling output. The checker module does the scoring.
// ----------------------------------------------------------------------------
module capability_escape_decoder_tb
    import cesc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [3:0] cfg_wdata = 4'd0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] in_char   = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       is_end;
    logic [6:0] pad_count;
    logic       last;
    int         fail_count;
    int         words_pending;

    int         burst_left;
    int         chars_sent;

    capability_escape_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_char   (in_char),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .is_end    (is_end),
        .pad_count (pad_count),
        .last      (last)
    );

    capability_escape_decoder_checker decode_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_char       (in_char),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .is_end        (is_end),
        .pad_count     (pad_count),
        .last          (last),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    always #1ns clk = ~clk;

    // offer one character, in bursts with random gaps
    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_char  <= c;
        do @(posedge clk); while (!in_ready);
        chars_sent++;
    endtask

    // random byte that has no special meaning in the body
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_NUL || c == CH_COLON || c == CH_CARET || c == CH_BSL);
        return c;
    endfunction

    function automatic logic [7:0] escape_letter(input int i);
        case (i)
            0:       return "E";
            1:       return CH_CARET;
            2:       return CH_BSL;
            3:       return CH_COLON;
            4:       return "n";
            5:       return "r";
            6:       return "t";
            7:       return "b";
            default: return "f";
        endcase
    endfunction

    function automatic logic [7:0] any_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // drain, let the block settle, then write the halvings register
    task automatic set_halvings(input logic [3:0] h);
        in_valid <= 1'b0;
        do @(posedge clk); while (words_pending != 0);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= h;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // one random capability value, mostly well formed
    task automatic send_value();
        int n_digits;
        int n_tokens;
        n_digits = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4);
        if ($urandom_range(0, 19) == 0)
            n_digits = $urandom_range(5, 7);
        repeat (n_digits) send_char(any_digit());
        n_tokens = $urandom_range(0, 8);
        repeat (n_tokens)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2:
                    send_char(plain_char());
                3:
                begin
                    send_char(CH_CARET);
                    send_char(8'($urandom_range(0, 255)));
                end
                4, 5:
                begin
                    send_char(CH_BSL);
                    send_char(escape_letter($urandom_range(0, 8)));
                end
                6:
                begin
                    send_char(CH_BSL);
                    send_char(8'($urandom_range(0, 255)));
                end
                7, 8:
                begin
                    // octal escape, second character sometimes not a digit
                    send_char(CH_BSL);
                    send_char(any_digit());
                    if ($urandom_range(0, 4) == 0)
                        send_char(plain_char());
                    else
                        send_char(any_digit());
                    if ($urandom_range(0, 2) != 0)
                        send_char(any_digit());
                    else
                        send_char(8'($urandom_range(0, 255)));
                end
                default:
                    send_char(8'($urandom_range(0, 255)));
            endcase
        end
        // terminator; sometimes none, so the next value runs on
        case ($urandom_range(0, 7))
            0:
                send_char(CH_NUL);
            1:
            begin
                send_char(CH_BSL);
                send_char(any_digit());
                send_char($urandom_range(0, 1) ? CH_COLON : CH_NUL);
            end
            2:
                ;
            default:
                send_char(CH_COLON);
        endcase
    endtask

    // result side: randomly chosen stall modes, plus long hold-offs
    initial
    begin : result_sink
        int cyc;
        int hold_left;
        int mode;
        cyc = 0;
        hold_left = 0;
        mode = 0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 1200 == 300)
                hold_left = 90;
            if (cyc % 64 == 0)
                mode = $urandom_range(0, 3);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (cyc % 3 != 0);
                endcase
            end
        end
    end

    // run limit
    initial
    begin
        #200us;
        $display("capability_escape_decoder regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        int phase_no;
        logic [3:0] setting;
        burst_left = 0;
        chars_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_halvings(4'd0);

        // directed: saturating delay, caret on colon and NUL, escaped NUL,
        // top byte, escape letter, then the end of the value
        repeat (5) send_char(CH_NINE);
        send_char(CH_CARET);
        send_char(CH_COLON);
        send_char(CH_CARET);
        send_char(CH_NUL);
        send_char(CH_BSL);
        send_char(CH_NUL);
        send_char(8'hFF);
        send_char(CH_BSL);
        send_char("E");
        send_char(CH_COLON);
        // octal with digits 8 and 9, octal cut short, octal ended by NUL
        send_char(CH_BSL);
        send_char(CH_NINE);
        send_char("8");
        send_char("7");
        send_char(CH_BSL);
        send_char("1");
        send_char("2");
        send_char("x");
        send_char(CH_BSL);
        send_char("3");
        send_char(CH_NUL);

        // random values under several settings
        for (phase_no = 0; phase_no < 4; phase_no++)
        begin
            case (phase_no)
                0:       setting = 4'd15;
                1:       setting = 4'($urandom_range(1, 14));
                2:       setting = 4'd1;
                default: setting = 4'd0;
            endcase
            set_halvings(setting);
            while (chars_sent < 26 + (phase_no + 1) * 100)
                send_value();
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (words_pending != 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && words_pending == 0)
            $display("capability_escape_decoder regression: pass");
        else
            $display("capability_escape_decoder regression: fail");
        $finish;
    end

endmodule
